### sv/nal2flv_pkg.sv
// nal2flv_pkg: shared types and constants for the nal to flv video tag packer
// no dependencies; imported by every module of the block
`default_nettype none

package nal2flv_pkg;

  // default configuration
  localparam int unsigned SPS_MAX_DEF   = 48;
  localparam int unsigned CMD_DEPTH_DEF = 4;

  // width of an sps store index, wide enough for the largest allowed store
  localparam int unsigned SPS_IDX_W = 6;

  // nal unit types of interest
  localparam logic [4:0] NAL_IDR = 5'd5;
  localparam logic [4:0] NAL_SPS = 5'd7;
  localparam logic [4:0] NAL_PPS = 5'd8;

  // fixed tag body bytes
  localparam logic [7:0] TAG_KEY_AVC   = 8'h17;
  localparam logic [7:0] TAG_INTER_AVC = 8'h27;
  localparam logic [7:0] BYTE_ONE      = 8'h01;
  localparam logic [7:0] BYTE_ZERO     = 8'h00;
  localparam logic [7:0] RESERVED_FF   = 8'hFF;
  localparam logic [7:0] NUM_SPS_E1    = 8'hE1;

  // header lengths in bytes
  localparam logic [5:0]  AVC_HDR_LEN     = 6'd13;
  localparam logic [5:0]  FRAME_HDR_LEN   = 6'd9;
  localparam logic [24:0] FRAME_HDR_BYTES = 25'd9;
  localparam logic [24:0] AVC_FIXED_BYTES = 25'd16;

  // work orders from the front to the back
  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_FRAME,
    CMD_PPS_FIRST,
    CMD_AVC
  } cmd_op_e;

  typedef struct packed {
    logic [4:0]  nal_type;
    logic [23:0] nal_length;
    logic [7:0]  data_byte;
    logic        last_byte;
  } nal_item_t;

  typedef struct packed {
    logic [7:0]  body_byte;
    logic        packet_kind;
    logic [24:0] body_size;
    logic        last_in_packet;
  } tag_item_t;

  typedef struct packed {
    cmd_op_e                op;
    logic [7:0]             data;
    logic                   last;
    logic                   kind;
    logic                   idr;
    logic [24:0]            size;
    logic [23:0]            plen;
    logic [SPS_IDX_W-1:0]   sps_len;
  } cmd_t;

  typedef struct packed {
    logic                 en;
    logic [SPS_IDX_W-1:0] addr;
    logic [7:0]           data;
  } sps_wr_t;

endpackage

`default_nettype wire

### sv/h264_nal_to_flv_video_tag_packer_top.sv
// H.264 Annex-B NAL bytes in, FLV AVC video tag body bytes out. One input
// transfer is one byte of a NAL unit; one output transfer is one body byte.
// Ordinary payload bytes pass at one per cycle while neither side stalls.
// The output side makes one byte per cycle while popped, which sets the rate:
// the first payload byte of a coded frame becomes 10 output bytes (9 header
// bytes plus itself), the first PPS byte 4, the last start code byte of a
// PPS 13 + SPS length (up to 61), read out of the SPS store byte by byte.
// A command queue of CMD_DEPTH entries lets input run ahead of these
// bursts; while an SPS replay is pending, full stays high until it is done.
// The SPS store needs no clearing after reset.
// depends on nal2flv_pkg, nal2flv_front, nal2flv_cmd_fifo, nal2flv_back
`default_nettype none

module h264_nal_to_flv_video_tag_packer_top #(
  parameter int unsigned SPS_MAX   = nal2flv_pkg::SPS_MAX_DEF,
  parameter int unsigned CMD_DEPTH = nal2flv_pkg::CMD_DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  nal2flv_pkg::nal_item_t nal_i,
  output logic                   empty,
  input  logic                   pop,
  output nal2flv_pkg::tag_item_t tag_o
);
  import nal2flv_pkg::*;

  cmd_t    cmd_in, cmd_out;
  logic    cmd_push, cmd_full, cmd_pop, cmd_valid;
  logic    avc_done;
  sps_wr_t sps_wr;

  // front: framing and classification
  nal2flv_front #(
    .SPS_MAX (SPS_MAX)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .nal_i      (nal_i),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in),
    .sps_wr_o   (sps_wr),
    .avc_done_i (avc_done)
  );

  // command queue
  nal2flv_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .valid_o (cmd_valid)
  );

  // back: byte generation
  nal2flv_back #(
    .SPS_MAX (SPS_MAX)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .avc_done_o  (avc_done),
    .sps_wr_i    (sps_wr),
    .empty       (empty),
    .pop         (pop),
    .tag_o       (tag_o)
  );

endmodule

`default_nettype wire

### sv/nal2flv_front.sv
// nal2flv_front: accepts nal bytes, tracks unit framing and sps state,
// writes the sps store and issues commands. depends on nal2flv_pkg
`default_nettype none

module nal2flv_front #(
  parameter int unsigned SPS_MAX = nal2flv_pkg::SPS_MAX_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  nal2flv_pkg::nal_item_t nal_i,
  input  logic                  cmd_full_i,
  output logic                  cmd_push_o,
  output nal2flv_pkg::cmd_t     cmd_o,
  output nal2flv_pkg::sps_wr_t  sps_wr_o,
  input  logic                  avc_done_i
);
  import nal2flv_pkg::*;

  localparam logic [23:0] POS_MAX    = '1;
  localparam logic [23:0] SPS_LEN_HI = 24'(SPS_MAX + 4);
  localparam logic [23:0] SPS_DEPTH  = 24'(SPS_MAX);
  localparam logic [2:0]  SKIP_LONG  = 3'd4;
  localparam logic [2:0]  SKIP_SHORT = 3'd3;

  logic [23:0]          pos_q, pos_d;
  logic [2:0]           skip_q, skip_d;
  logic [SPS_IDX_W-1:0] splen_q, splen_d;
  logic                 valid_q, valid_d;
  logic                 dropped_q, dropped_d;
  logic                 replay_q;

  logic                 accept;
  logic                 pos_zero, is_sps, is_pps;
  logic                 dropped_e, valid_e;
  logic [2:0]           skip_e;
  logic [SPS_IDX_W-1:0] splen_e;
  logic [23:0]          len, sps_idx, plen;
  logic                 cmd_valid, wr_hit;

  // stall while the queue is full or a stored sps is being replayed
  assign full       = cmd_full_i || replay_q;
  assign accept     = push && !full;
  assign cmd_push_o = accept && cmd_valid;
  assign len        = nal_i.nal_length;

  // classify the byte and work out the next state
  always_comb begin
    pos_zero  = (pos_q == '0);
    is_sps    = (nal_i.nal_type == NAL_SPS);
    is_pps    = (nal_i.nal_type == NAL_PPS);
    dropped_e = dropped_q;
    skip_e    = skip_q;
    splen_e   = splen_q;
    valid_e   = valid_q;

    // decisions taken on the first byte of a unit
    if (pos_zero) begin
      dropped_e = 1'b0;
      skip_e    = (is_sps || is_pps) ? SKIP_LONG : '0;
      if (is_sps) begin
        valid_e = 1'b0;
        if (len < 24'd8 || len > SPS_LEN_HI) begin
          dropped_e = 1'b1;
          splen_e   = '0;
        end else begin
          splen_e = SPS_IDX_W'(len - 24'd4);
        end
      end else if (is_pps) begin
        if (!valid_q || len < 24'd5) begin
          dropped_e = 1'b1;
        end
      end
    end

    skip_d    = skip_e;
    valid_d   = valid_e;
    dropped_d = dropped_e;
    splen_d   = splen_e;
    cmd_valid = 1'b0;
    wr_hit    = 1'b0;
    sps_idx   = pos_q - 24'd4;
    plen      = len - 24'd4;

    cmd_o         = '0;
    cmd_o.op      = CMD_BYTE;
    cmd_o.data    = nal_i.data_byte;
    cmd_o.sps_len = splen_e;
    cmd_o.last    = (pos_q == len - 24'd1);

    if (is_sps) begin
      // store sps bytes after the start code
      if (!dropped_e && pos_q >= 24'd4 && sps_idx < {18'd0, splen_e} &&
          sps_idx < SPS_DEPTH) begin
        wr_hit = 1'b1;
        if (sps_idx + 24'd1 == {18'd0, splen_e}) begin
          valid_d = 1'b1;
        end
      end
    end else if (is_pps) begin
      // sequence header on the last start code byte, then pps bytes
      if (!dropped_e && valid_e && len >= 24'd5 && pos_q >= 24'd3 && pos_q < len) begin
        cmd_valid  = 1'b1;
        cmd_o.kind = 1'b1;
        cmd_o.size = AVC_FIXED_BYTES + 25'(splen_e) + {1'b0, plen};
        if (pos_q == 24'd3) begin
          cmd_o.op = CMD_AVC;
        end else if (pos_q == 24'd4) begin
          cmd_o.op = CMD_PPS_FIRST;
        end
      end
    end else begin
      // coded frame: start code length settles on byte 2
      if (pos_q == 24'd2 && skip_e == '0) begin
        skip_d = (nal_i.data_byte == BYTE_ZERO) ? SKIP_LONG : SKIP_SHORT;
      end
      plen = len - {21'd0, skip_d};
      if (skip_d != '0 && pos_q >= {21'd0, skip_d} && pos_q < len) begin
        cmd_valid  = 1'b1;
        cmd_o.kind = 1'b0;
        cmd_o.idr  = (nal_i.nal_type == NAL_IDR);
        cmd_o.size = FRAME_HDR_BYTES + {1'b0, plen};
        if (pos_q == {21'd0, skip_d}) begin
          cmd_o.op = CMD_FRAME;
        end
      end
    end
    cmd_o.plen = plen;

    // unit framing
    if (nal_i.last_byte) begin
      pos_d = '0;
    end else if (pos_q != POS_MAX) begin
      pos_d = pos_q + 24'd1;
    end else begin
      pos_d = pos_q;
    end
  end

  // sps store write port
  always_comb begin
    sps_wr_o      = '0;
    sps_wr_o.en   = accept && wr_hit;
    sps_wr_o.addr = sps_idx[SPS_IDX_W-1:0];
    sps_wr_o.data = nal_i.data_byte;
  end

  // unit state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      skip_q    <= '0;
      splen_q   <= '0;
      valid_q   <= 1'b0;
      dropped_q <= 1'b0;
    end else if (accept) begin
      pos_q     <= pos_d;
      skip_q    <= skip_d;
      splen_q   <= splen_d;
      valid_q   <= valid_d;
      dropped_q <= dropped_d;
    end
  end

  // replay in progress: hold the store until the back has read it out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      replay_q <= 1'b0;
    end else if (cmd_push_o && cmd_o.op == CMD_AVC) begin
      replay_q <= 1'b1;
    end else if (avc_done_i) begin
      replay_q <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### sv/nal2flv_cmd_fifo.sv
// nal2flv_cmd_fifo: short command queue between the front and the back
// depends on nal2flv_pkg
`default_nettype none

module nal2flv_cmd_fifo #(
  parameter int unsigned DEPTH = nal2flv_pkg::CMD_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  nal2flv_pkg::cmd_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output nal2flv_pkg::cmd_t data_o,
  output logic              valid_o
);
  import nal2flv_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  cmd_t          entries_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          do_push, do_pop;

  assign full_o  = (count_q == CNT_FULL);
  assign valid_o = (count_q != '0);
  assign data_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### sv/nal2flv_back.sv
// nal2flv_back: expands commands into tag body bytes, one per cycle when
// the output slot frees up, holds the sps store. depends on nal2flv_pkg
`default_nettype none

module nal2flv_back #(
  parameter int unsigned SPS_MAX = nal2flv_pkg::SPS_MAX_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  nal2flv_pkg::cmd_t     cmd_i,
  input  logic                  cmd_valid_i,
  output logic                  cmd_pop_o,
  output logic                  avc_done_o,
  input  nal2flv_pkg::sps_wr_t  sps_wr_i,
  output logic                  empty,
  input  logic                  pop,
  output nal2flv_pkg::tag_item_t tag_o
);
  import nal2flv_pkg::*;

  localparam int unsigned AW = $clog2(SPS_MAX);

  logic [7:0]           sps_mem [SPS_MAX];
  logic [7:0]           rd_data_q;

  logic [5:0]           step_q;
  logic                 out_valid_q;
  logic                 src_mem_q;
  logic [7:0]           byte_q;
  logic                 kind_q;
  logic [24:0]          size_q;
  logic                 last_q;

  logic                 adv, final_step;
  logic [5:0]           last_step;
  logic [5:0]           rd_idx;
  logic                 src_mem;
  logic [7:0]           byte_n;
  logic                 last_n;

  // step through the current command when the output slot frees up
  assign adv        = cmd_valid_i && (!out_valid_q || pop);
  assign final_step = (step_q == last_step);
  assign cmd_pop_o  = adv && final_step;
  assign avc_done_o = cmd_pop_o && (cmd_i.op == CMD_AVC);

  // byte for the current step
  always_comb begin
    src_mem   = 1'b0;
    byte_n    = BYTE_ZERO;
    last_n    = 1'b0;
    rd_idx    = step_q - AVC_HDR_LEN;
    last_step = '0;
    case (cmd_i.op)
      CMD_BYTE: begin
        byte_n = cmd_i.data;
        last_n = cmd_i.last;
      end
      CMD_FRAME: begin
        last_step = FRAME_HDR_LEN;
        case (step_q) inside
          6'd0:        byte_n = cmd_i.idr ? TAG_KEY_AVC : TAG_INTER_AVC;
          6'd1:        byte_n = BYTE_ONE;
          [6'd2:6'd5]: byte_n = BYTE_ZERO;
          6'd6:        byte_n = cmd_i.plen[23:16];
          6'd7:        byte_n = cmd_i.plen[15:8];
          6'd8:        byte_n = cmd_i.plen[7:0];
          default: begin
            byte_n = cmd_i.data;
            last_n = cmd_i.last;
          end
        endcase
      end
      CMD_PPS_FIRST: begin
        last_step = 6'd3;
        case (step_q) inside
          6'd0:    byte_n = BYTE_ONE;
          6'd1:    byte_n = cmd_i.plen[15:8];
          6'd2:    byte_n = cmd_i.plen[7:0];
          default: begin
            byte_n = cmd_i.data;
            last_n = cmd_i.last;
          end
        endcase
      end
      CMD_AVC: begin
        last_step = AVC_HDR_LEN + cmd_i.sps_len - 6'd1;
        case (step_q) inside
          6'd0:        byte_n = TAG_KEY_AVC;
          [6'd1:6'd4]: byte_n = BYTE_ZERO;
          6'd5:        byte_n = BYTE_ONE;
          [6'd6:6'd8]: begin
            // profile, compatibility and level from the stored sps
            src_mem = 1'b1;
            rd_idx  = step_q - 6'd5;
          end
          6'd9:        byte_n = RESERVED_FF;
          6'd10:       byte_n = NUM_SPS_E1;
          6'd11:       byte_n = BYTE_ZERO;
          6'd12:       byte_n = {2'b00, cmd_i.sps_len};
          default:     src_mem = 1'b1;
        endcase
      end
      default: begin
        byte_n = cmd_i.data;
        last_n = cmd_i.last;
      end
    endcase
  end

  // sps store, registered read
  always_ff @(posedge clk_i) begin
    if (sps_wr_i.en) begin
      sps_mem[sps_wr_i.addr[AW-1:0]] <= sps_wr_i.data;
    end
    if (adv && src_mem) begin
      rd_data_q <= sps_mem[rd_idx[AW-1:0]];
    end
  end

  // step counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        step_q      <= final_step ? '0 : step_q + 6'd1;
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      src_mem_q <= src_mem;
      byte_q    <= byte_n;
      kind_q    <= cmd_i.kind;
      size_q    <= cmd_i.size;
      last_q    <= last_n;
    end
  end

  assign empty                = !out_valid_q;
  assign tag_o.body_byte      = src_mem_q ? rd_data_q : byte_q;
  assign tag_o.packet_kind    = kind_q;
  assign tag_o.body_size      = size_q;
  assign tag_o.last_in_packet = last_q;

endmodule

`default_nettype wire

### sv/nal2flv_checker.sv
// nal2flv_checker: port level checks on the packer top, bound in below
// depends on nal2flv_pkg and h264_nal_to_flv_video_tag_packer_top
`default_nettype none

module nal2flv_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   push,
  input logic                   full,
  input logic                   empty,
  input logic                   pop,
  input nal2flv_pkg::tag_item_t tag_o
);

  // a waiting body byte holds until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(tag_o))
    else $error("body byte changed before transfer");

  // nothing waits and input is open straight after reset
  a_reset_clear: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> empty && !full)
    else $error("not clear after reset");

  // backpressure can only build up from an input transfer
  a_full_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !full && !push |=> !full)
    else $error("full raised without input");

endmodule

bind h264_nal_to_flv_video_tag_packer_top nal2flv_checker u_checker (.*);

`default_nettype wire

### bench/tb_h264_nal_to_flv_video_tag_packer_top.sv
`timescale 1ns / 100ps
// tb_h264_nal_to_flv_video_tag_packer_top: self-checking bench for the nal to flv tag packer
// streams nal unit bytes in, predicts every tag body byte and checks each output transfer
// depends on nal2flv_pkg and h264_nal_to_flv_video_tag_packer_top

module tb_h264_nal_to_flv_video_tag_packer_top;
  import nal2flv_pkg::*;

  localparam int unsigned SPS_MAX       = SPS_MAX_DEF;
  localparam int unsigned POS_SAT       = 32'h00FF_FFFF;
  localparam logic        KIND_FRAME    = 1'b0;
  localparam logic        KIND_SEQ_HDR  = 1'b1;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned RANDOM_BYTES  = 100;
  localparam int unsigned LONG_HOLD     = 400;
  localparam logic [4:0]  NAL_NON_IDR   = 5'd1;
  localparam logic [4:0]  NAL_TYPE_MIN  = 5'd0;
  localparam logic [4:0]  NAL_TYPE_MAX  = 5'd31;
  localparam int          FILL_RANDOM   = -1;

  logic      clk_i;
  logic      rst_ni;
  logic      push;
  logic      full;
  nal_item_t nal_i;
  logic      empty;
  logic      pop;
  tag_item_t tag_o;

  // predictor state, one copy of what the packer keeps
  int unsigned unit_pos  = 0;
  int unsigned sc_skip   = 0;
  logic [7:0]  sps_mem [SPS_MAX];
  int unsigned sps_len   = 0;
  bit          sps_held  = 1'b0;
  bit          unit_drop = 1'b0;

  tag_item_t   tag_expect_q[$];
  int unsigned mismatch_count  = 0;
  bit          send_gaps       = 1'b1;
  bit          pop_gaps        = 1'b1;
  int unsigned pop_hold_cycles = 0;

  h264_nal_to_flv_video_tag_packer_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .nal_i  (nal_i),
    .empty  (empty),
    .pop    (pop),
    .tag_o  (tag_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // queue one predicted body byte
  task automatic expect_tag(input logic [7:0] b, input logic kind, input int unsigned size,
                            input logic last);
    tag_item_t t;
    t.body_byte      = b;
    t.packet_kind    = kind;
    t.body_size      = 25'(size);
    t.last_in_packet = last;
    tag_expect_q.push_back(t);
  endtask

  // predict the body bytes caused by one nal byte
  task automatic pack_expected_tags(input nal_item_t it);
    int unsigned pos;
    int unsigned len;
    int unsigned plen;
    int unsigned size;
    logic        last;
    pos = unit_pos;
    len = it.nal_length;
    // unit-wide decisions on byte 0
    if (pos == 0) begin
      unit_drop = 1'b0;
      sc_skip   = (it.nal_type == NAL_SPS || it.nal_type == NAL_PPS) ? 4 : 0;
      if (it.nal_type == NAL_SPS) begin
        sps_held = 1'b0;
        if (len < 8 || len - 4 > SPS_MAX) begin
          unit_drop = 1'b1;
          sps_len   = 0;
        end else begin
          sps_len = len - 4;
        end
      end else if (it.nal_type == NAL_PPS) begin
        if (!sps_held || len < 5) unit_drop = 1'b1;
      end
    end
    last = (pos == len - 1);
    if (it.nal_type == NAL_SPS) begin
      // store the sps body behind its start code
      if (!unit_drop && pos >= 4 && pos - 4 < sps_len) begin
        sps_mem[pos - 4] = it.data_byte;
        if (pos - 4 == sps_len - 1) sps_held = 1'b1;
      end
    end else if (it.nal_type == NAL_PPS) begin
      // avc sequence header
      if (!unit_drop && sps_held && len >= 5 && pos >= 3 && pos < len) begin
        plen = len - 4;
        size = 16 + sps_len + plen;
        if (pos == 3) begin
          expect_tag(TAG_KEY_AVC, KIND_SEQ_HDR, size, 1'b0);
          repeat (4) expect_tag(BYTE_ZERO, KIND_SEQ_HDR, size, 1'b0);
          expect_tag(BYTE_ONE, KIND_SEQ_HDR, size, 1'b0);
          expect_tag(sps_mem[1], KIND_SEQ_HDR, size, 1'b0);
          expect_tag(sps_mem[2], KIND_SEQ_HDR, size, 1'b0);
          expect_tag(sps_mem[3], KIND_SEQ_HDR, size, 1'b0);
          expect_tag(RESERVED_FF, KIND_SEQ_HDR, size, 1'b0);
          expect_tag(NUM_SPS_E1, KIND_SEQ_HDR, size, 1'b0);
          expect_tag(BYTE_ZERO, KIND_SEQ_HDR, size, 1'b0);
          expect_tag(8'(sps_len), KIND_SEQ_HDR, size, 1'b0);
          for (int unsigned i = 0; i < sps_len; i++)
            expect_tag(sps_mem[i], KIND_SEQ_HDR, size, 1'b0);
        end else begin
          if (pos == 4) begin
            expect_tag(BYTE_ONE, KIND_SEQ_HDR, size, 1'b0);
            expect_tag(8'(plen >> 8), KIND_SEQ_HDR, size, 1'b0);
            expect_tag(8'(plen), KIND_SEQ_HDR, size, 1'b0);
          end
          expect_tag(it.data_byte, KIND_SEQ_HDR, size, last);
        end
      end
    end else begin
      // coded frame, start code length known from byte 2
      if (pos == 2 && sc_skip == 0) sc_skip = (it.data_byte == BYTE_ZERO) ? 4 : 3;
      if (sc_skip != 0 && pos >= sc_skip && pos < len) begin
        plen = len - sc_skip;
        size = 9 + plen;
        if (pos == sc_skip) begin
          expect_tag((it.nal_type == NAL_IDR) ? TAG_KEY_AVC : TAG_INTER_AVC,
                     KIND_FRAME, size, 1'b0);
          expect_tag(BYTE_ONE, KIND_FRAME, size, 1'b0);
          repeat (3) expect_tag(BYTE_ZERO, KIND_FRAME, size, 1'b0);
          expect_tag(8'(plen >> 24), KIND_FRAME, size, 1'b0);
          expect_tag(8'(plen >> 16), KIND_FRAME, size, 1'b0);
          expect_tag(8'(plen >> 8), KIND_FRAME, size, 1'b0);
          expect_tag(8'(plen), KIND_FRAME, size, 1'b0);
        end
        expect_tag(it.data_byte, KIND_FRAME, size, last);
      end
    end
    // unit framing
    if (it.last_byte) unit_pos = 0;
    else if (unit_pos < POS_SAT) unit_pos = unit_pos + 1;
  endtask

  // offer one nal byte and wait for its transfer
  task automatic send_nal_byte(input nal_item_t it);
    int unsigned gap;
    gap = send_gaps ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pack_expected_tags(it);
    nal_i <= it;
    push  <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  // one nal unit: start code of sc_len bytes (0 for raw bytes), then payload
  task automatic send_nal_unit(input logic [4:0] ntype, input int unsigned nbytes,
                               input logic [23:0] len_field, input int unsigned sc_len,
                               input int fill);
    nal_item_t it;
    for (int unsigned i = 0; i < nbytes; i++) begin
      it.nal_type   = ntype;
      it.nal_length = len_field;
      it.last_byte  = (i == nbytes - 1);
      if (i < sc_len) it.data_byte = (i == sc_len - 1) ? BYTE_ONE : BYTE_ZERO;
      else if (fill >= 0) it.data_byte = 8'(fill);
      else it.data_byte = 8'($urandom);
      send_nal_byte(it);
    end
  endtask

  // sender idles until every predicted byte has come out
  task automatic wait_tags_drained();
    push <= 1'b0;
    while (tag_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // pps with no sps held gives nothing
  task automatic test_pps_without_sps();
    send_nal_unit(NAL_PPS, 5, 5, 4, FILL_RANDOM);
  endtask

  // too short an sps is dropped, the smallest legal one is kept
  task automatic test_sps_size_limits();
    send_nal_unit(NAL_SPS, 7, 7, 4, FILL_RANDOM);
    send_nal_unit(NAL_SPS, 8, 8, 4, FILL_RANDOM);
  endtask

  // smallest pps yields a sequence header
  task automatic test_sequence_header();
    send_nal_unit(NAL_PPS, 5, 5, 4, FILL_RANDOM);
  endtask

  // idr and non-idr frames, both start code lengths, short frame
  task automatic test_coded_frames();
    send_nal_unit(NAL_IDR, 4, 4, 3, 8'hFF);
    send_nal_unit(NAL_NON_IDR, 6, 5, 4, 8'h00);
    send_nal_unit(NAL_NON_IDR, 3, 3, 3, FILL_RANDOM);
  endtask

  // length field extremes and units cut short
  task automatic test_length_mismatch();
    send_nal_unit(NAL_TYPE_MIN, 4, 24'd0, 3, FILL_RANDOM);
    send_nal_unit(NAL_TYPE_MAX, 6, 24'hFF_FFFF, 3, FILL_RANDOM);
    // oversized sps clears the held one, so the next pps is dropped
    send_nal_unit(NAL_SPS, 5, SPS_MAX + 5, 4, FILL_RANDOM);
    send_nal_unit(NAL_PPS, 5, 5, 4, FILL_RANDOM);
  endtask

  // receiver stalls for a long stretch while bursts keep arriving
  task automatic test_full_backpressure();
    send_gaps       = 1'b0;
    pop_gaps        = 1'b0;
    pop_hold_cycles = LONG_HOLD;
    send_nal_unit(NAL_SPS, SPS_MAX + 4, SPS_MAX + 4, 4, FILL_RANDOM);
    send_nal_unit(NAL_PPS, 12, 12, 4, FILL_RANDOM);
    send_nal_unit(NAL_IDR, 40, 40, 4, FILL_RANDOM);
    send_nal_unit(NAL_NON_IDR, 40, 40, 3, FILL_RANDOM);
  endtask

  // mostly well-formed units with random content, some broken units and noise
  task automatic test_random_units();
    int unsigned sent;
    int unsigned len;
    int unsigned nb;
    int unsigned pick;
    int unsigned sc;
    logic [4:0]  t;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      send_gaps = ($urandom_range(0, 3) != 0);
      pop_gaps  = ($urandom_range(0, 3) != 0);
      pick      = $urandom_range(0, 99);
      if (pick < 25) begin
        // sps, mostly small, sometimes up to the store size, sometimes cut short
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(8, SPS_MAX + 4)
                                          : $urandom_range(8, 14);
        nb  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, len) : len;
        send_nal_unit(NAL_SPS, nb, 24'(len), 4, FILL_RANDOM);
        sent += nb;
      end else if (pick < 50) begin
        // pps, with an occasional huge length field
        len = $urandom_range(5, 16);
        nb  = len;
        if ($urandom_range(0, 7) == 0) begin
          nb = $urandom_range(5, 10);
          send_nal_unit(NAL_PPS, nb, 24'($urandom), 4, FILL_RANDOM);
        end else begin
          if ($urandom_range(0, 4) == 0) nb = $urandom_range(1, len + 3);
          send_nal_unit(NAL_PPS, nb, 24'(len), 4, FILL_RANDOM);
        end
        sent += nb;
      end else if (pick < 85) begin
        // coded frame
        do t = 5'($urandom_range(0, 31)); while (t == NAL_SPS || t == NAL_PPS);
        if ($urandom_range(0, 2) == 0) t = NAL_IDR;
        sc  = $urandom_range(3, 4);
        len = $urandom_range(sc, sc + 24);
        nb  = len;
        if ($urandom_range(0, 7) == 0) begin
          nb = $urandom_range(sc, sc + 6);
          send_nal_unit(t, nb, 24'($urandom), sc, FILL_RANDOM);
        end else begin
          if ($urandom_range(0, 4) == 0) nb = $urandom_range(1, len + 3);
          send_nal_unit(t, nb, 24'(len), sc, FILL_RANDOM);
        end
        sent += nb;
      end else begin
        // noise: raw bytes, any type and length field
        nb = $urandom_range(1, 12);
        send_nal_unit(5'($urandom), nb, 24'($urandom), 0, FILL_RANDOM);
        sent += nb;
      end
    end
  endtask

  // receiver: random waits, one long hold when asked
  initial begin : tag_receiver
    int unsigned wait_n;
    pop <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (pop_hold_cycles != 0) begin
        wait_n          = pop_hold_cycles;
        pop_hold_cycles = 0;
      end else begin
        wait_n = pop_gaps ? $urandom_range(0, 19) : 0;
      end
      if (wait_n != 0) begin
        pop <= 1'b0;
        repeat (wait_n) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
    end
  end

  // compare each output transfer with the oldest prediction
  always @(posedge clk_i) begin : tag_check
    tag_item_t want;
    if (rst_ni === 1'b1 && pop === 1'b1 && empty === 1'b0) begin
      if (tag_expect_q.size() == 0) begin
        $error("unexpected body byte transfer: body_byte %0h", tag_o.body_byte);
        mismatch_count++;
      end else begin
        want = tag_expect_q.pop_front();
        if (tag_o.body_byte !== want.body_byte) begin
          $error("body_byte: expected %0h, got %0h", want.body_byte, tag_o.body_byte);
          mismatch_count++;
        end
        if (tag_o.packet_kind !== want.packet_kind) begin
          $error("packet_kind: expected %0d, got %0d", want.packet_kind, tag_o.packet_kind);
          mismatch_count++;
        end
        if (tag_o.body_size !== want.body_size) begin
          $error("body_size: expected %0d, got %0d", want.body_size, tag_o.body_size);
          mismatch_count++;
        end
        if (tag_o.last_in_packet !== want.last_in_packet) begin
          $error("last_in_packet: expected %0d, got %0d", want.last_in_packet,
                 tag_o.last_in_packet);
          mismatch_count++;
        end
      end
    end
  end

  // reset, tests in turn, verdict
  initial begin : stimulus
    rst_ni <= 1'b0;
    push   <= 1'b0;
    nal_i  <= '0;
    for (int i = 0; i < SPS_MAX; i++) sps_mem[i] = 8'h00;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_pps_without_sps();
    test_sps_size_limits();
    test_sequence_header();
    test_coded_frames();
    test_length_mismatch();
    wait_tags_drained();
    test_full_backpressure();
    wait_tags_drained();
    test_random_units();
    wait_tags_drained();
    if (mismatch_count == 0) begin
      $display("** h264_nal_to_flv_video_tag_packer_top: PASSED **");
    end else begin
      $display("** h264_nal_to_flv_video_tag_packer_top: FAILED **");
    end
    $finish;
  end

  // run limit
  initial begin : run_limit
    #30_000_000;
    $display("** h264_nal_to_flv_video_tag_packer_top: FAILED **");
    $finish;
  end

endmodule

### sim.f
sv/nal2flv_pkg.sv
sv/nal2flv_front.sv
sv/nal2flv_cmd_fifo.sv
sv/nal2flv_back.sv
sv/h264_nal_to_flv_video_tag_packer_top.sv
sv/nal2flv_checker.sv
bench/tb_h264_nal_to_flv_video_tag_packer_top.sv
